// File: design/udrb_pkg.sv
// Shared types and constants for the dual UART ring buffer.
// Operation and status codes, field widths, controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps

package udrb_pkg;

    localparam int DEFAULT_RING_DEPTH = 64;

    localparam int OP_W      = 2;
    localparam int BYTE_W    = 8;
    localparam int STATUS_W  = 3;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    typedef enum logic [OP_W-1:0] {
        OP_HOST_SEND = 2'd0,
        OP_HOST_RECV = 2'd1,
        OP_LINE_RX   = 2'd2,
        OP_TX_READY  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 3'd0,
        ST_TX_FULL  = 3'd1,
        ST_RX_EMPTY = 3'd2,
        ST_OVERRUN  = 3'd3,
        ST_TX_IDLE  = 3'd4
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic    load;
        logic    exec;
        logic    tx_push;
        logic    tx_pop;
        logic    rx_push;
        logic    rx_pop;
        logic    irq_set;
        logic    irq_clr;
        status_t status;
    } udrb_cmd_t;

    // datapath to controller
    typedef struct packed {
        op_t  op;
        logic rx_empty;
        logic rx_full;
        logic tx_empty;
        logic tx_full;
    } udrb_flags_t;

endpackage

// File: design/udrb_ctrl.sv
// Controller for the dual UART ring buffer: handshake sequencing and per-item decisions.
// Depends on udrb_pkg; drives udrb_datapath through udrb_cmd_t.
`timescale 1ns / 1ps

module udrb_ctrl
    import udrb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  udrb_flags_t flags,
    output udrb_cmd_t   cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_RESP);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // decide the ring action and status for the held item
    always_comb
    begin
        cmd         = '0;
        cmd.status  = ST_DONE;
        cmd.load    = (state_reg == S_IDLE) && s_tvalid;
        cmd.exec    = (state_reg == S_EXEC);
        if (state_reg == S_EXEC)
        begin
            unique case (flags.op)
                OP_HOST_SEND:
                begin
                    if (flags.tx_full)
                    begin
                        cmd.status = ST_TX_FULL;
                    end
                    else
                    begin
                        cmd.tx_push = 1'b1;
                        cmd.irq_set = 1'b1;
                    end
                end
                OP_HOST_RECV:
                begin
                    if (flags.rx_empty)
                    begin
                        cmd.status = ST_RX_EMPTY;
                    end
                    else
                    begin
                        cmd.rx_pop = 1'b1;
                    end
                end
                OP_LINE_RX:
                begin
                    // write regardless; a full ring overruns onto the read position
                    cmd.rx_push = 1'b1;
                    if (flags.rx_full)
                    begin
                        cmd.status = ST_OVERRUN;
                    end
                end
                OP_TX_READY:
                begin
                    if (flags.tx_empty)
                    begin
                        cmd.irq_clr = 1'b1;
                        cmd.status  = ST_TX_IDLE;
                    end
                    else
                    begin
                        cmd.tx_pop = 1'b1;
                    end
                end
                default:
                begin
                    cmd.status = ST_DONE;
                end
            endcase
        end
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input accepted while a result is pending");

    a_exec_to_resp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> m_tvalid)
        else $error("executed item did not present a result");

    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.tx_push, cmd.tx_pop, cmd.rx_push, cmd.rx_pop}))
        else $error("more than one ring action in a cycle");

endmodule

// File: design/udrb_datapath.sv
// Datapath for the dual UART ring buffer: item register, both rings, pointers,
// interrupt flag and result register. Depends on udrb_pkg; steered by udrb_ctrl.
`timescale 1ns / 1ps

module udrb_datapath
    import udrb_pkg::*;
#(
    parameter int RING_DEPTH = DEFAULT_RING_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic [M_TDATA_W-1:0] m_tdata,
    input  udrb_cmd_t            cmd,
    output udrb_flags_t          flags
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(RING_DEPTH - 1);

    function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
        next_pos = (p == LAST_POS) ? '0 : p + 1'b1;
    endfunction

    op_t               op_reg;
    logic [BYTE_W-1:0] data_reg;

    logic [BYTE_W-1:0] rx_mem [RING_DEPTH];
    logic [BYTE_W-1:0] tx_mem [RING_DEPTH];

    logic [PTR_W-1:0] rx_wr_reg, rx_wr_next;
    logic [PTR_W-1:0] rx_rd_reg, rx_rd_next;
    logic [PTR_W-1:0] tx_wr_reg, tx_wr_next;
    logic [PTR_W-1:0] tx_rd_reg, tx_rd_next;
    logic             tx_irq_reg, tx_irq_next;

    status_t           status_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              byte_valid_reg;
    logic [BYTE_W-1:0] byte_out;

    // hold the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op_t'(s_tdata[OP_W-1:0]);
            data_reg <= s_tdata[OP_W +: BYTE_W];
        end
    end

    assign flags.op       = op_reg;
    assign flags.rx_empty = (rx_wr_reg == rx_rd_reg);
    assign flags.rx_full  = (next_pos(rx_wr_reg) == rx_rd_reg);
    assign flags.tx_empty = (tx_wr_reg == tx_rd_reg);
    assign flags.tx_full  = (next_pos(tx_wr_reg) == tx_rd_reg);

    always_comb
    begin
        rx_wr_next  = cmd.rx_push ? next_pos(rx_wr_reg) : rx_wr_reg;
        rx_rd_next  = cmd.rx_pop  ? next_pos(rx_rd_reg) : rx_rd_reg;
        tx_wr_next  = cmd.tx_push ? next_pos(tx_wr_reg) : tx_wr_reg;
        tx_rd_next  = cmd.tx_pop  ? next_pos(tx_rd_reg) : tx_rd_reg;
        tx_irq_next = tx_irq_reg;
        if (cmd.irq_set)
        begin
            tx_irq_next = 1'b1;
        end
        else if (cmd.irq_clr)
        begin
            tx_irq_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_wr_reg  <= '0;
            rx_rd_reg  <= '0;
            tx_wr_reg  <= '0;
            tx_rd_reg  <= '0;
            tx_irq_reg <= 1'b0;
        end
        else
        begin
            rx_wr_reg  <= rx_wr_next;
            rx_rd_reg  <= rx_rd_next;
            tx_wr_reg  <= tx_wr_next;
            tx_rd_reg  <= tx_rd_next;
            tx_irq_reg <= tx_irq_next;
        end
    end

    // ring storage: one write and one registered read per ring
    always_ff @(posedge clk)
    begin
        if (cmd.rx_push)
        begin
            rx_mem[rx_wr_reg] <= data_reg;
        end
        if (cmd.tx_push)
        begin
            tx_mem[tx_wr_reg] <= data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            byte_reg       <= cmd.rx_pop ? rx_mem[rx_rd_reg] : tx_mem[tx_rd_reg];
            byte_valid_reg <= cmd.rx_pop || cmd.tx_pop;
            status_reg     <= cmd.status;
        end
    end

    assign byte_out = byte_valid_reg ? byte_reg : '0;

    assign m_tdata = {{(M_TDATA_W - STATUS_W - BYTE_W - 2){1'b0}},
                      tx_irq_reg, byte_valid_reg, byte_out, status_reg};

    a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && (cmd.rx_pop || cmd.tx_pop)) |=>
            (byte_valid_reg && (status_reg == ST_DONE)))
        else $error("pop did not yield a valid byte with done status");

    a_overrun_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rx_push && flags.rx_full) |=> flags.rx_empty)
        else $error("overrun did not leave the receive ring empty");

    a_send_sets_irq: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tx_push |=> (!flags.tx_empty && tx_irq_reg))
        else $error("host send left transmit ring empty or interrupt clear");

endmodule

// File: design/uart_dual_ring_buffer_core.sv
// Dual UART ring buffer, top level: receive and transmit byte rings with a
// transmit-interrupt enable flag. Each item passes through accept, ring access with
// registered memory read, and result, and the result is held while it is stalled;
// one item in flight at a time.
// Reset (rst_n, asynchronous, active low) clears pointers and flag; ring contents
// are left undefined until written.
`timescale 1ns / 1ps

module uart_dual_ring_buffer_core
    import udrb_pkg::*;
#(
    parameter int RING_DEPTH = DEFAULT_RING_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // [1:0] operation, [9:2] data_in, rest zero
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // [2:0] status, [10:3] byte_out,
                                           // [11] byte_valid, [12] tx_irq_enabled
);

    udrb_cmd_t   cmd;
    udrb_flags_t flags;

    udrb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .flags    (flags),
        .cmd      (cmd)
    );

    udrb_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata),
        .cmd     (cmd),
        .flags   (flags)
    );

endmodule
